/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/core/fdst_pkg.sv */
package fdst_pkg;

    localparam int DELTA_W           = 10;
    localparam int TIME_W            = 32;
    localparam int FPS_W             = 16;
    localparam int WIN_W             = 16;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 16;
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int UPC_W             = 4;
    localparam int CNT_W             = $clog2(DELTA_W);

    localparam logic [DELTA_W-1:0] MAX_STEP_RST = DELTA_W'(100);
    localparam logic [WIN_W-1:0]   WINDOW_RST   = WIN_W'(1000);
    // a rounding loss below this moves the last-frame time back
    localparam logic [DELTA_W-1:0] FIX_LIMIT    = DELTA_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_WINDOW = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        FUNC_FRAME = 2'd0,
        FUNC_RESET = 2'd1,
        FUNC_LOAD  = 2'd2,
        FUNC_PAUSE = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NOP, OP_STEP, OP_MONO, OP_DELTA, OP_PUSH, OP_RD0, OP_ACC, OP_DIVI,
        OP_DIV, OP_FIX, OP_ADV, OP_RATE, OP_RST, OP_OUT, OP_LOAD, OP_PAUSE
    } t_op;

    typedef enum logic [2:0] {
        JC_SEQ, JC_GOTO, JC_HOLD_IN, JC_HOLD_OUT, JC_MORE, JC_CNT, JC_IF_RST
    } t_jc;

    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_IDLE  = 4'd0;
    localparam t_upc U_STEP  = 4'd1;
    localparam t_upc U_MONO  = 4'd2;
    localparam t_upc U_DELTA = 4'd3;
    localparam t_upc U_PUSH  = 4'd4;
    localparam t_upc U_RD0   = 4'd5;
    localparam t_upc U_ACC   = 4'd6;
    localparam t_upc U_DIVI  = 4'd7;
    localparam t_upc U_DIV   = 4'd8;
    localparam t_upc U_FIX   = 4'd9;
    localparam t_upc U_ADV   = 4'd10;
    localparam t_upc U_RATE  = 4'd11;
    localparam t_upc U_RST   = 4'd12;
    localparam t_upc U_DONE  = 4'd13;
    localparam t_upc U_LOAD  = 4'd14;
    localparam t_upc U_PAUSE = 4'd15;

    typedef struct packed {
        t_op  op;
        t_jc  jc;
        t_upc target;
    } t_uword;

    typedef struct packed {
        logic more;     // history entries left to sum
        logic cnt_nz;   // divider iterations left
        logic is_rst;   // item in flight is a timer reset
    } t_dp_status;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    function automatic t_uword ucode_rom(input t_upc addr);
        t_uword w;
        case (addr)
            U_IDLE:  w = '{OP_NOP,   JC_HOLD_IN,  U_IDLE};
            U_STEP:  w = '{OP_STEP,  JC_SEQ,      U_IDLE};
            U_MONO:  w = '{OP_MONO,  JC_IF_RST,   U_RST};
            U_DELTA: w = '{OP_DELTA, JC_SEQ,      U_IDLE};
            U_PUSH:  w = '{OP_PUSH,  JC_SEQ,      U_IDLE};
            U_RD0:   w = '{OP_RD0,   JC_SEQ,      U_IDLE};
            U_ACC:   w = '{OP_ACC,   JC_MORE,     U_ACC};
            U_DIVI:  w = '{OP_DIVI,  JC_SEQ,      U_IDLE};
            U_DIV:   w = '{OP_DIV,   JC_CNT,      U_DIV};
            U_FIX:   w = '{OP_FIX,   JC_SEQ,      U_IDLE};
            U_ADV:   w = '{OP_ADV,   JC_SEQ,      U_IDLE};
            U_RATE:  w = '{OP_RATE,  JC_GOTO,     U_DONE};
            U_RST:   w = '{OP_RST,   JC_SEQ,      U_IDLE};
            U_DONE:  w = '{OP_OUT,   JC_HOLD_OUT, U_IDLE};
            U_LOAD:  w = '{OP_LOAD,  JC_GOTO,     U_DONE};
            U_PAUSE: w = '{OP_PAUSE, JC_GOTO,     U_DONE};
            default: w = '{OP_NOP,   JC_GOTO,     U_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_upc func_entry(input t_func f);
        t_upc e;
        case (f)
            FUNC_FRAME: e = U_STEP;
            FUNC_RESET: e = U_STEP;
            FUNC_LOAD:  e = U_LOAD;
            FUNC_PAUSE: e = U_PAUSE;
            default:    e = U_IDLE;
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/fdst_ram.sv */
module fdst_ram #(
    parameter int WIDTH = fdst_pkg::DELTA_W,
    parameter int DEPTH = fdst_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fdst_seq.sv */
module fdst_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_accept,
    input  logic                 i_out_free,
    input  fdst_pkg::t_func      i_func,
    input  fdst_pkg::t_dp_status i_status,
    output fdst_pkg::t_op        o_op,
    output logic                 o_idle
);
    import fdst_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_word;

    assign w_word = ucode_rom(r_upc);

    // next step
    always_comb begin
        case (w_word.jc)
            JC_SEQ:      n_upc = r_upc + 1'b1;
            JC_GOTO:     n_upc = w_word.target;
            JC_HOLD_IN:  n_upc = i_in_accept ? func_entry(i_func) : r_upc;
            JC_HOLD_OUT: n_upc = i_out_free ? w_word.target : r_upc;
            JC_MORE:     n_upc = i_status.more ? w_word.target : r_upc + 1'b1;
            JC_CNT:      n_upc = i_status.cnt_nz ? w_word.target : r_upc + 1'b1;
            JC_IF_RST:   n_upc = i_status.is_rst ? w_word.target : r_upc + 1'b1;
            default:     n_upc = U_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_op   = w_word.op;
        o_idle = (r_upc == U_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

/* rtl/core/fdst_dp.sv */
`include "assert_macros.svh"

module fdst_dp #(
    parameter int HISTORY_DEPTH = fdst_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  fdst_pkg::t_func               i_func,
    input  logic [fdst_pkg::TIME_W-1:0]   i_time_sample,
    input  logic [fdst_pkg::TIME_W-1:0]   i_load_value,
    input  logic                          i_pause_value,
    input  fdst_pkg::t_op                 i_op,
    input  fdst_pkg::t_cfg_wr             i_cfg,
    output fdst_pkg::t_dp_status          o_status,
    output logic [fdst_pkg::DELTA_W-1:0]  o_delta_ms,
    output logic [fdst_pkg::TIME_W-1:0]   o_game_time,
    output logic [fdst_pkg::TIME_W-1:0]   o_total_ms,
    output logic [fdst_pkg::FPS_W-1:0]    o_fps
);
    import fdst_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = FW + DELTA_W;
    localparam logic [AW-1:0] HEAD_LAST  = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL  = FW'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DELTA_W - 1);
    localparam int PAD_T = TIME_W - DELTA_W;

    // configuration
    logic [DELTA_W-1:0] r_max_step;
    logic [WIN_W-1:0]   r_window;

    // timer state
    logic [TIME_W-1:0]  r_last_raw, n_last_raw;
    logic               r_raw_seen, n_raw_seen;
    logic [TIME_W-1:0]  r_mono,     n_mono;
    logic [TIME_W-1:0]  r_prev,     n_prev;
    logic [FW-1:0]      r_fill,     n_fill;
    logic [AW-1:0]      r_head,     n_head;
    logic [DELTA_W-1:0] r_smooth,   n_smooth;
    logic [TIME_W-1:0]  r_game,     n_game;
    logic               r_paused,   n_paused;
    logic [TIME_W-1:0]  r_deadline, n_deadline;
    logic [FPS_W-1:0]   r_tally,    n_tally;
    logic [FPS_W-1:0]   r_shown,    n_shown;

    // working registers of one item
    t_func              r_func;
    logic [TIME_W-1:0]  r_raw;
    logic [TIME_W-1:0]  r_load;
    logic               r_pv;
    logic [DELTA_W-1:0] r_t,     n_t;
    logic [DELTA_W-1:0] r_delta, n_delta;
    logic [SW-1:0]      r_sum,   n_sum;
    logic [FW-1:0]      r_idx,   n_idx;
    logic [SW-1:0]      r_rem,   n_rem;
    logic [SW-1:0]      r_dsr,   n_dsr;
    logic [DELTA_W-1:0] r_quo,   n_quo;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;

    logic [TIME_W-1:0]  w_max32;
    logic [TIME_W-1:0]  w_step;
    logic [TIME_W-1:0]  w_frame;
    logic [DELTA_W-1:0] w_gap;
    logic               w_ge;
    logic               w_fire;
    logic               w_we;
    logic [AW-1:0]      w_raddr;
    logic [DELTA_W-1:0] w_rdata;

    assign w_max32 = {{PAD_T{1'b0}}, r_max_step};
    assign w_step  = r_raw_seen ? (r_raw - r_last_raw) : '0;
    assign w_frame = r_mono - r_prev;
    assign w_gap   = r_delta - r_quo;
    assign w_ge    = (r_rem >= r_dsr);
    assign w_fire  = (r_deadline < r_mono);

    always_comb begin
        n_last_raw = r_last_raw;
        n_raw_seen = r_raw_seen;
        n_mono     = r_mono;
        n_prev     = r_prev;
        n_fill     = r_fill;
        n_head     = r_head;
        n_smooth   = r_smooth;
        n_game     = r_game;
        n_paused   = r_paused;
        n_deadline = r_deadline;
        n_tally    = r_tally;
        n_shown    = r_shown;
        n_t        = r_t;
        n_delta    = r_delta;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_rem      = r_rem;
        n_dsr      = r_dsr;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        w_we       = 1'b0;
        w_raddr    = '0;
        case (i_op)
            OP_STEP: begin
                // clamp the raw step; the first sample counts as no step
                n_t        = (w_step > w_max32) ? r_max_step : w_step[DELTA_W-1:0];
                n_last_raw = r_raw;
                n_raw_seen = 1'b1;
            end
            OP_MONO: begin
                n_mono = r_mono + {{PAD_T{1'b0}}, r_t};
            end
            OP_DELTA: begin
                n_delta = (w_frame > w_max32) ? r_max_step : w_frame[DELTA_W-1:0];
            end
            OP_PUSH: begin
                w_we   = 1'b1;
                n_head = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
                if (r_fill != FILL_FULL) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            OP_RD0: begin
                w_raddr = '0;
                n_sum   = '0;
                n_idx   = FW'(1);
            end
            OP_ACC: begin
                // add the entry read last cycle, fetch the next one
                n_sum = r_sum + {{FW{1'b0}}, w_rdata};
                if (r_idx < FILL_FULL) begin
                    w_raddr = r_idx[AW-1:0];
                end
                n_idx = r_idx + 1'b1;
            end
            OP_DIVI: begin
                // mean fits the delta width, so align the divisor to its top bit
                n_rem = r_sum;
                n_dsr = {1'b0, r_fill, {(DELTA_W-1){1'b0}}};
                n_quo = '0;
                n_cnt = CNT_INIT;
            end
            OP_DIV: begin
                n_rem = w_ge ? (r_rem - r_dsr) : r_rem;
                n_quo = {r_quo[DELTA_W-2:0], w_ge};
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt - 1'b1;
            end
            OP_FIX: begin
                n_smooth = r_quo;
                n_t = ((r_delta > r_quo) && (w_gap < FIX_LIMIT)) ? w_gap : '0;
            end
            OP_ADV: begin
                n_prev = r_mono - {{PAD_T{1'b0}}, r_t};
                if (!r_paused) begin
                    n_game = r_game + {{PAD_T{1'b0}}, r_smooth};
                end
            end
            OP_RATE: begin
                if (w_fire) begin
                    n_deadline = r_mono + {{(TIME_W-WIN_W){1'b0}}, r_window};
                    n_shown    = r_tally;
                    n_tally    = FPS_W'(1);
                end else if (r_tally != '1) begin
                    n_tally = r_tally + 1'b1;
                end
            end
            OP_RST: begin
                n_prev     = r_mono;
                n_paused   = 1'b0;
                n_deadline = '0;
                n_tally    = '0;
                n_shown    = '0;
            end
            OP_LOAD: begin
                n_game = r_load;
            end
            OP_PAUSE: begin
                n_paused = r_pv;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step <= MAX_STEP_RST;
            r_window   <= WINDOW_RST;
            r_last_raw <= '0;
            r_raw_seen <= 1'b0;
            r_mono     <= '0;
            r_prev     <= '0;
            r_fill     <= '0;
            r_head     <= '0;
            r_smooth   <= '0;
            r_game     <= '0;
            r_paused   <= 1'b0;
            r_deadline <= '0;
            r_tally    <= '0;
            r_shown    <= '0;
        end else begin
            if (i_cfg.valid && (i_cfg.index == CFG_MAX_STEP)) begin
                r_max_step <= i_cfg.data[DELTA_W-1:0];
            end
            if (i_cfg.valid && (i_cfg.index == CFG_RATE_WINDOW)) begin
                r_window <= i_cfg.data[WIN_W-1:0];
            end
            r_last_raw <= n_last_raw;
            r_raw_seen <= n_raw_seen;
            r_mono     <= n_mono;
            r_prev     <= n_prev;
            r_fill     <= n_fill;
            r_head     <= n_head;
            r_smooth   <= n_smooth;
            r_game     <= n_game;
            r_paused   <= n_paused;
            r_deadline <= n_deadline;
            r_tally    <= n_tally;
            r_shown    <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_func <= i_func;
            r_raw  <= i_time_sample;
            r_load <= i_load_value;
            r_pv   <= i_pause_value;
        end
        r_t     <= n_t;
        r_delta <= n_delta;
        r_sum   <= n_sum;
        r_idx   <= n_idx;
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
    end

    fdst_ram #(
        .WIDTH (DELTA_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_head),
        .i_wdata (r_delta),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_status.more   = (r_idx < r_fill);
    assign o_status.cnt_nz = (r_cnt != '0);
    assign o_status.is_rst = (r_func == FUNC_RESET);

    assign o_delta_ms  = r_smooth;
    assign o_game_time = r_game;
    assign o_total_ms  = r_mono;
    assign o_fps       = r_shown;

    `ASSERT_IMP(a_fill_before_sum, i_clk, i_rst_n, i_op == OP_RD0, r_fill != '0)
    `ASSERT_IMP(a_sum_bound, i_clk, i_rst_n, i_op == OP_DIVI, r_sum < {r_fill, {DELTA_W{1'b0}}})
    `ASSERT_IMP(a_rem_bound, i_clk, i_rst_n, i_op == OP_FIX, r_rem < {{DELTA_W{1'b0}}, r_fill})

endmodule

/* rtl/core/frame_delta_smoothing_timer_core.sv */
// Channel   Dir  Handshake                       Payload (low bit up)
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: func; tdata: time_sample,
//                                                load_value, pause_value
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: delta_ms, game_time,
//                                                total_ms, fps
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// A frame update sums the history entries held after the push (one RAM read a
// cycle), divides with the 10-step restoring divider and loads the result register;
// the next beat can be taken in the following cycle. A timer reset runs only the
// step, mono and reset steps before the load; load and pause go straight to it.
// Reset is synchronous, active low; history RAM is not cleared.
// The result register lets the next input beat in while a result waits; a
// stalled m_axis holds the sequencer on its final step and no result is dropped.
`include "assert_macros.svh"

module frame_delta_smoothing_timer_core #(
    parameter int HISTORY_DEPTH = fdst_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] func
    input  logic [1:0]                        s_axis_tuser,
    // [31:0] time_sample, [63:32] load_value, [64] pause_value, [71:65] zero
    input  logic [71:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [9:0] delta_ms, [41:10] game_time, [73:42] total_ms, [89:74] fps, [95:90] zero
    output logic [95:0]                       m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fdst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fdst_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fdst_pkg::*;

    t_op                w_op;
    logic               w_idle;
    logic               w_in_accept;
    logic               w_out_free;
    logic               w_out_load;
    t_func              w_func;
    t_dp_status         w_status;
    t_cfg_wr            w_cfg;
    logic [DELTA_W-1:0] w_delta_ms;
    logic [TIME_W-1:0]  w_game_time;
    logic [TIME_W-1:0]  w_total_ms;
    logic [FPS_W-1:0]   w_fps;

    logic               r_out_valid;
    logic [95:0]        r_out_data;

    // take input only while the sequencer waits for work
    assign s_axis_tready = w_idle;
    assign w_in_accept   = s_axis_tvalid && w_idle;
    assign w_func        = t_func'(s_axis_tuser);

    // config writes are always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // result register frees up when empty or drained this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (w_op == OP_OUT) && w_out_free;

    fdst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_out_free  (w_out_free),
        .i_func      (w_func),
        .i_status    (w_status),
        .o_op        (w_op),
        .o_idle      (w_idle)
    );

    fdst_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_func        (w_func),
        .i_time_sample (s_axis_tdata[31:0]),
        .i_load_value  (s_axis_tdata[63:32]),
        .i_pause_value (s_axis_tdata[64]),
        .i_op          (w_op),
        .i_cfg         (w_cfg),
        .o_status      (w_status),
        .o_delta_ms    (w_delta_ms),
        .o_game_time   (w_game_time),
        .o_total_ms    (w_total_ms),
        .o_fps         (w_fps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // capture the result beat; hold it while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {6'b0, w_fps, w_total_ms, w_game_time, w_delta_ms};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_out_load, !r_out_valid || m_axis_tready)
    `ASSERT_NXT(a_result_shown, i_clk, i_rst_n, w_out_load, m_axis_tvalid)

endmodule

/* verif/frame_delta_smoothing_timer_core_tb.sv */
module frame_delta_smoothing_timer_core_tb;
    import fdst_pkg::*;

    localparam int HIST_DEPTH  = HISTORY_DEPTH_DEF;
    // cycles with no beat on any channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // long receiver hold-off: starts after this many results, lasts this many cycles
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        t_func       func;
        logic [31:0] sample;
        logic [31:0] load_val;
        logic        pause_val;
    } timer_cmd_t;

    typedef struct {
        logic [9:0]  delta;
        logic [31:0] game;
        logic [31:0] total;
        logic [15:0] fps;
    } timer_reading_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser  = '0;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    frame_delta_smoothing_timer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Timer state mirror: updated once per accepted command beat
    // ------------------------------------------------------------------
    logic [9:0]  max_step_q = MAX_STEP_RST;
    logic [15:0] window_q   = WINDOW_RST;

    logic [31:0] last_raw_q   = '0;
    logic        raw_seen_q   = 1'b0;
    logic [31:0] mono_q       = '0;
    logic [31:0] prev_frame_q = '0;
    logic [9:0]  hist_q [HIST_DEPTH];
    int unsigned hist_fill_q  = 0;
    int unsigned hist_head_q  = 0;
    logic [9:0]  smooth_q     = '0;
    logic [31:0] game_q       = '0;
    logic        paused_q     = 1'b0;
    logic [31:0] deadline_q   = '0;
    logic [15:0] tally_q      = '0;
    logic [15:0] shown_q      = '0;

    timer_cmd_t     timer_cmds_q[$];
    timer_reading_t timer_readings_q[$];
    timer_cmd_t     cur_cmd;

    int          err_count    = 0;
    int          results_seen = 0;
    int          idle_pct     = 0;
    bit          calm         = 1'b0;
    int unsigned frame_ms     = 16;
    logic [31:0] gen_raw      = '0;

    // Clamp the raw step (modular, so a clock wrap gives a small step) and
    // advance the monotonic time. The very first sample only seeds last_raw.
    function automatic void clock_in_sample(input logic [31:0] raw);
        logic [31:0] step;
        step = raw_seen_q ? raw - last_raw_q : 32'd0;
        last_raw_q = raw;
        raw_seen_q = 1'b1;
        if (step > 32'(max_step_q))
            step = 32'(max_step_q);
        mono_q = mono_q + step;
    endfunction

    function automatic timer_reading_t advance_timer(input timer_cmd_t cmd);
        timer_reading_t r;
        logic [31:0] delta, sum, mean;
        case (cmd.func)
            FUNC_FRAME: begin
                clock_in_sample(cmd.sample);
                delta = mono_q - prev_frame_q;
                if (delta > 32'(max_step_q))
                    delta = 32'(max_step_q);
                hist_q[hist_head_q] = delta[9:0];
                hist_head_q = (hist_head_q + 1) % HIST_DEPTH;
                if (hist_fill_q < HIST_DEPTH)
                    hist_fill_q++;
                // average only the entries written so far
                sum = '0;
                for (int unsigned i = 0; i < hist_fill_q; i++)
                    sum = sum + 32'(hist_q[i]);
                mean = sum / hist_fill_q;
                smooth_q = mean[9:0];
                // pull the frame reference back by a small rounding loss
                prev_frame_q = mono_q;
                if (delta > mean && delta - mean < 32'(FIX_LIMIT))
                    prev_frame_q = prev_frame_q - (delta - mean);
                if (!paused_q)
                    game_q = game_q + 32'(smooth_q);
                if (deadline_q < mono_q) begin
                    deadline_q = mono_q + 32'(window_q);
                    shown_q    = tally_q;
                    tally_q    = '0;
                end
                if (tally_q != 16'hFFFF)
                    tally_q++;
            end
            FUNC_RESET: begin
                clock_in_sample(cmd.sample);
                prev_frame_q = mono_q;
                paused_q     = 1'b0;
                deadline_q   = '0;
                tally_q      = '0;
                shown_q      = '0;
            end
            FUNC_LOAD:  game_q   = cmd.load_val;
            default:    paused_q = cmd.pause_val;
        endcase
        r.delta = smooth_q;
        r.game  = game_q;
        r.total = mono_q;
        r.fps   = shown_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command generation
    // ------------------------------------------------------------------
    function automatic timer_cmd_t mk_cmd(input t_func f, input logic [31:0] sample,
                                          input logic [31:0] load_val, input logic pv);
        timer_cmd_t c;
        c.func      = f;
        c.sample    = sample;
        c.load_val  = load_val;
        c.pause_val = pv;
        // track the raw clock so well-formed frames follow on from it
        if (f == FUNC_FRAME || f == FUNC_RESET)
            gen_raw = sample;
        return c;
    endfunction

    // append a command to the pending queue
    function automatic void queue_cmd(input timer_cmd_t c);
        timer_cmds_q.insert(timer_cmds_q.size(), c);
    endfunction

    // Mostly steady frames with jitter just above the nominal frame time, plus
    // missed frames, raw clock jumps, timer resets, loads and pause toggles.
    function automatic timer_cmd_t next_random_cmd();
        int unsigned pick, step;
        logic [31:0] ld;
        pick = $urandom_range(99);
        if (pick < 80) begin
            case ($urandom_range(9))
                0:       step = 0;
                1, 2:    step = $urandom_range(2 * max_step_q + 2);
                default: step = frame_ms + $urandom_range(6);
            endcase
            return mk_cmd(FUNC_FRAME, gen_raw + step, $urandom, 1'($urandom_range(1)));
        end else if (pick < 84) begin
            return mk_cmd(FUNC_FRAME, $urandom, $urandom, 1'($urandom_range(1)));
        end else if (pick < 88) begin
            return mk_cmd(FUNC_RESET, gen_raw + $urandom_range(50), $urandom,
                          1'($urandom_range(1)));
        end else if (pick < 93) begin
            // loads near the top exercise the game time wrap
            ld = $urandom_range(1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(5000);
            return mk_cmd(FUNC_LOAD, $urandom, ld, 1'($urandom_range(1)));
        end
        return mk_cmd(FUNC_PAUSE, $urandom, $urandom, 1'($urandom_range(1)));
    endfunction

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Command driver: takes from the pending queue, predicts on every accepted beat
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge i_clk) begin : cmd_driver
        logic held;
        logic next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            held = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                timer_readings_q.insert(timer_readings_q.size(), advance_timer(cur_cmd));
            // hold the beat until taken, then either idle or offer the next one
            if (!held) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (timer_cmds_q.size() > 0) begin
                    if (!calm && $urandom_range(99) < idle_pct) begin
                        gap_left = $urandom_range(4, 1) - 1;
                    end else begin
                        cur_cmd = timer_cmds_q[0];
                        timer_cmds_q.delete(0);
                        s_axis_tuser <= cur_cmd.func;
                        s_axis_tdata <= {7'd0, cur_cmd.pause_val, cur_cmd.load_val,
                                         cur_cmd.sample};
                        next_valid = 1'b1;
                    end
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each beat against the oldest prediction
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        timer_reading_t want;
        logic next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (timer_readings_q.size() == 0) begin
                    $error("result beat with no prediction pending");
                    err_count++;
                end else begin
                    want = timer_readings_q[0];
                    timer_readings_q.delete(0);
                    check_field("delta_ms",  32'(want.delta), 32'(m_axis_tdata[9:0]));
                    check_field("game_time", want.game,       m_axis_tdata[41:10]);
                    check_field("total_ms",  want.total,      m_axis_tdata[73:42]);
                    check_field("fps",       32'(want.fps),   32'(m_axis_tdata[89:74]));
                end
            end
            // one long hold-off lets the block back up into its input
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (!hold_done && results_seen == HOLD_AT) begin
                hold_done  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!calm && $urandom_range(99) < idle_pct) begin
                stall_left = $urandom_range(4, 1) - 1;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_axis_tready <= next_ready;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (timer_cmds_q.size() != 0 || s_axis_tvalid || timer_readings_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_MAX_STEP)
            max_step_q = data[9:0];
        else if (idx == CFG_RATE_WINDOW)
            window_q = data;
        i_cfg_valid <= 1'b0;
    endtask

    // Reconfigure only with nothing in flight, then set the idling for the phase.
    task automatic settle_and_configure(input logic [9:0] max_step, input logic [15:0] window,
                                        input int pct, input bit quiet);
        wait_drained();
        write_reg(CFG_MAX_STEP, CFG_DATA_W'(max_step));
        write_reg(CFG_RATE_WINDOW, window);
        @(negedge i_clk);
        idle_pct = pct;
        calm     = quiet;
        frame_ms = $urandom_range(40, 10);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first sample, raw wrap, zero and clamped steps, load
        // extremes with a game time wrap, pause both ways, reset clearing pause.
        settle_and_configure(10'd100, 16'd1000, 30, 1'b0);
        queue_cmd(mk_cmd(FUNC_FRAME, 32'hFFFF_FFF0, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h0000_0005, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h0000_0005, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0000, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0010, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_LOAD,  $urandom, 32'hFFFF_FFFF, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0020, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_LOAD,  $urandom, 32'h0000_0000, 1'b0));
        queue_cmd(mk_cmd(FUNC_PAUSE, $urandom, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0030, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0041, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_PAUSE, $urandom, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0050, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0062, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_0071, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_PAUSE, $urandom, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_RESET, 32'h8000_00A0, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h8000_00B0, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h0000_0000, $urandom, 1'b0));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'hFFFF_FFFF, $urandom, 1'b1));
        queue_cmd(mk_cmd(FUNC_FRAME, 32'h0000_0003, $urandom, 1'b0));

        // max step of zero freezes time, so even a one-ms window stops latching the frame count
        settle_and_configure(10'd0, 16'd1, 30, 1'b0);
        repeat (120) queue_cmd(next_random_cmd());

        settle_and_configure(10'd1000, 16'd65535, 40, 1'b0);
        repeat (300) queue_cmd(next_random_cmd());

        settle_and_configure(10'd1, 16'd1, 20, 1'b0);
        repeat (100) queue_cmd(next_random_cmd());

        settle_and_configure(10'($urandom_range(200, 20)), 16'($urandom_range(3000, 200)),
                             35, 1'b0);
        repeat (400) queue_cmd(next_random_cmd());

        // last stretch runs at full rate on both sides
        settle_and_configure(10'd100, 16'd1000, 0, 1'b1);
        repeat (500) queue_cmd(next_random_cmd());

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fdst_pkg.sv
rtl/core/fdst_ram.sv
rtl/core/fdst_seq.sv
rtl/core/fdst_dp.sv
rtl/core/frame_delta_smoothing_timer_core.sv
verif/frame_delta_smoothing_timer_core_tb.sv
